FILE: rtl/nsr_pkg.sv
// Shared constants and register codes for the Newton square root block.
package nsr_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 32;

  localparam int TOL_W      = 32;
  localparam int ITER_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TOL_W-1:0]  TOL_RESET        = 32'd1;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'd1;

endpackage

FILE: rtl/nsr_mul.sv
// Iterative squarer: one half-width multiplier over four partial products.
module nsr_mul #(
  parameter int VALUE_BITS = nsr_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [VALUE_BITS-1:0]     opnd_i,
  output logic                      done_o,
  output logic [2*VALUE_BITS-1:0]   prod_o
);

  localparam int H  = (VALUE_BITS + 1) / 2;
  localparam int AW = 4 * H;

  logic [VALUE_BITS-1:0] a_q;
  logic [2*H-1:0]        pp_q;
  logic [1:0]            sh_q;
  logic                  pv_q;
  logic [AW-1:0]         acc_q;
  logic [2:0]            cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [H-1:0]  xl;
  logic [H-1:0]  xh;
  logic [H-1:0]  opa;
  logic [H-1:0]  opb;
  logic [1:0]    sh;
  logic [AW-1:0] pp_sh;

  assign xl  = a_q[H-1:0];
  assign xh  = H'(a_q >> H);
  assign opa = cnt_q[1] ? xh : xl;
  assign opb = cnt_q[0] ? xh : xl;
  assign sh  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};

  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = AW'(pp_q);
      2'd1:    pp_sh = AW'(pp_q) << H;
      2'd2:    pp_sh = AW'(pp_q) << (2 * H);
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      a_q    <= '0;
      pp_q   <= '0;
      sh_q   <= '0;
      acc_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
        pv_q   <= 1'b0;
        acc_q  <= '0;
        a_q    <= opnd_i;
      end else if (busy_q) begin
        if (cnt_q < 3'd4) begin
          pp_q <= opa * opb;
          sh_q <= sh;
          pv_q <= 1'b1;
        end
        if (pv_q) begin
          acc_q <= acc_q + pp_sh;
        end
        cnt_q  <= cnt_q + 3'd1;
        done_q <= (cnt_q == 3'd4);
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[2*VALUE_BITS-1:0];

endmodule

FILE: rtl/nsr_div.sv
// Radix-2 restoring divider with quotient saturation.
module nsr_div #(
  parameter int VALUE_BITS = nsr_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2*VALUE_BITS-2:0]   num_i,
  input  logic [VALUE_BITS-1:0]     den_i,
  output logic                      done_o,
  output logic [VALUE_BITS-1:0]     quo_o
);

  localparam int NW = 2 * VALUE_BITS - 1;
  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] den_q;
  logic [VALUE_BITS-1:0] rem_q;
  logic [VALUE_BITS-1:0] quo_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [VALUE_BITS-1:0] num_hi;
  logic                  ovf;
  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   rem_sub;
  logic                  ge;

  assign num_hi  = VALUE_BITS'(num_i[NW-1:VALUE_BITS]);
  assign ovf     = num_hi >= den_i;
  assign rem_sh  = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      if (start_i) begin
        den_q  <= den_i;
        rem_q  <= num_hi;
        cnt_q  <= '0;
        done_q <= ovf;
        if (ovf) begin
          quo_q  <= '1;
          busy_q <= 1'b0;
        end else begin
          quo_q  <= num_i[VALUE_BITS-1:0];
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= ge ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
        quo_q  <= {quo_q[VALUE_BITS-2:0], ge};
        cnt_q  <= cnt_q + CW'(1);
        done_q <= (cnt_q == CW'(VALUE_BITS - 1));
        if (cnt_q == CW'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/newton_square_root.sv
// Newton-Raphson square root of an unsigned fixed-point radicand.
//
// Input channel: radicand_i with in_valid_i / in_stall_o; a word is taken when
// valid is high and stall is low. Output channel: root_o, iterations_o and
// converged_o with out_valid_o / out_stall_i. One result word per radicand.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 = tolerance, 1 = max_iterations); write only while the block is idle.
// One radicand is processed at a time; in_stall_o is high from accept until
// the result is loaded into the output register.
// Each Newton update squares x over four partial products on one half-width
// multiplier, runs a residual test, then the radix-2 divider, which takes
// VALUE_BITS steps unless its quotient saturates. The run ends on a residual
// below tolerance, on x at zero or at max_iterations; the output register
// then takes the result. A new radicand is accepted while the previous result
// still waits there; the block holds its next result until that is taken.
// Reset clears the sequencer and output valid and sets tolerance to 1 LSB and
// max_iterations to 100. FRAC_BITS must be below VALUE_BITS.
module newton_square_root #(
  parameter int VALUE_BITS = nsr_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nsr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [VALUE_BITS-1:0]            radicand_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [VALUE_BITS-1:0]            root_o,
  output logic [nsr_pkg::ITER_W-1:0]       iterations_o,
  output logic                             converged_o
);

  localparam int SQW  = 2 * VALUE_BITS - FRAC_BITS;
  localparam int NW   = 2 * VALUE_BITS - 1;
  localparam int CMPW = (SQW > nsr_pkg::TOL_W) ? SQW : nsr_pkg::TOL_W;
  localparam logic [VALUE_BITS-1:0] FixOne = VALUE_BITS'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_MUL,
    S_RESID,
    S_DIVGO,
    S_DIV,
    S_OUT
  } state_e;

  state_e                        state_q;
  logic [nsr_pkg::TOL_W-1:0]     tol_q;
  logic [nsr_pkg::ITER_W-1:0]    iter_limit_q;
  logic [VALUE_BITS-1:0]         n_q;
  logic [VALUE_BITS-1:0]         x_q;
  logic [nsr_pkg::ITER_W-1:0]    iters_q;
  logic                          conv_q;
  logic [SQW-1:0]                mag_q;
  logic                          pos_q;
  logic                          out_valid_q;
  logic [VALUE_BITS-1:0]         root_q;
  logic [nsr_pkg::ITER_W-1:0]    iterations_q;
  logic                          converged_q;

  logic                          mul_start;
  logic                          mul_done;
  logic [2*VALUE_BITS-1:0]       mul_prod;
  logic                          div_start;
  logic                          div_done;
  logic [VALUE_BITS-1:0]         div_quo;

  logic [VALUE_BITS-1:0]         x_init;
  logic [SQW-1:0]                sq;
  logic [SQW-1:0]                n_ext;
  logic                          pos;
  logic [SQW-1:0]                mag;
  logic                          below_tol;
  logic [NW-1:0]                 num;
  logic [VALUE_BITS:0]           x_sum;
  logic [VALUE_BITS-1:0]         x_next;
  logic                          out_free;
  logic                          out_load;
  logic                          in_accept;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == S_OUT) && out_free;

  assign x_init    = ((radicand_i >> 1) < FixOne) ? FixOne : (radicand_i >> 1);
  assign sq        = mul_prod[2*VALUE_BITS-1:FRAC_BITS];
  assign n_ext     = SQW'(n_q);
  assign pos       = sq >= n_ext;
  assign mag       = pos ? (sq - n_ext) : (n_ext - sq);
  assign below_tol = CMPW'(mag) < CMPW'(tol_q);
  assign num       = {mag_q, {(FRAC_BITS - 1){1'b0}}};

  assign x_sum = {1'b0, x_q} + {1'b0, div_quo};
  always_comb begin
    if (pos_q) begin
      x_next = (div_quo >= x_q) ? '0 : (x_q - div_quo);
    end else begin
      x_next = x_sum[VALUE_BITS] ? '1 : x_sum[VALUE_BITS-1:0];
    end
  end

  assign mul_start = (state_q == S_LOOP) && (iters_q < iter_limit_q);
  assign div_start = (state_q == S_DIVGO);

  nsr_mul #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .opnd_i (x_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  nsr_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (x_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= nsr_pkg::TOL_RESET;
      iter_limit_q <= nsr_pkg::ITER_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nsr_pkg::CFG_TOLERANCE:  tol_q        <= cfg_data_i[nsr_pkg::TOL_W-1:0];
        nsr_pkg::CFG_ITER_LIMIT: iter_limit_q <= cfg_data_i[nsr_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= '0;
      x_q          <= '0;
      iters_q      <= '0;
      conv_q       <= 1'b0;
      mag_q        <= '0;
      pos_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      root_q       <= '0;
      iterations_q <= '0;
      converged_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            n_q     <= radicand_i;
            x_q     <= x_init;
            iters_q <= '0;
            conv_q  <= 1'b0;
            state_q <= S_LOOP;
          end
        end
        S_LOOP: begin
          state_q <= mul_start ? S_MUL : S_OUT;
        end
        S_MUL: begin
          if (mul_done) begin
            state_q <= S_RESID;
          end
        end
        S_RESID: begin
          if (below_tol) begin
            conv_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (x_q == '0) begin
            state_q <= S_OUT;
          end else begin
            mag_q   <= mag;
            pos_q   <= pos;
            state_q <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            x_q     <= x_next;
            iters_q <= iters_q + nsr_pkg::ITER_W'(1);
            state_q <= S_LOOP;
          end
        end
        S_OUT: begin
          if (out_free) begin
            root_q       <= x_q;
            iterations_q <= iters_q;
            converged_q  <= conv_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign iterations_o = iterations_q;
  assign converged_o  = converged_q;

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("squarer finished outside its wait state");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_resid_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESID |-> $past(mul_done))
    else $error("residual test without a fresh square");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result word loaded outside output state");

endmodule
